/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SVA_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SVA_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sva_pkg.sv */
// ----------------------------------------------------------------------------
// sva_pkg
// Types, constants and codes of the voice allocator.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int VOICES      = 8;
  localparam int STACK_DEPTH = 16;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SCAN_W = (VIDX_W > SIDX_W) ? VIDX_W : SIDX_W;
  localparam int STAMP_W = 32;

  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic [1:0] REG_MONO   = 2'd0;
  localparam logic [1:0] REG_LEGATO = 2'd1;
  localparam logic [1:0] REG_LFO    = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_t;

  typedef struct packed {
    logic       voice_changed;
    logic [2:0] voice_index;
    logic [6:0] voice_note;
    logic [6:0] voice_velocity;
    logic       voice_gate;
    logic       env_retrigger;
    logic       stolen;
    logic       lfo_restart;
    logic       global_gate;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_STK,
    S_STK_UPD,
    S_SCAN_VOC,
    S_VOC_UPD,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SCAN_STK,
    OP_STK_UPD,
    OP_SCAN_VOC,
    OP_VOC_UPD,
    OP_CLEAR,
    OP_NOEVT
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       mono;
    logic       stk_done;
    logic       voc_done;
    logic       to_voc;
    logic       out_free;
  } dp_sts_t;

endpackage

/* sv/synth_voice_allocator.sv */
// ----------------------------------------------------------------------------
// synth_voice_allocator
// Note event to voice allocator with oldest-voice stealing and a mono stack.
// ----------------------------------------------------------------------------
// One transaction in gives exactly one transaction out. The block handles one
// event at a time: an accept, then a sequential scan in the datapath (of the
// note stack in mono mode; of the voice table in poly mode and on a mono
// release that falls back to the voice table, after a stack update), then an
// update. Clear-all and idle codes skip the scans. A new event is taken only
// in the idle state; the result register holds the previous transaction until
// the sink takes it, and the final update waits for that register to be free.
// Configuration writes are always accepted (cfg_ready_o is tied high); mono
// mode takes effect on the next event, legato and LFO retrigger are read at
// each update. Registers: 0 mono mode, 1 legato, 2 LFO retrigger. Writes to
// index 3 are dropped.
module synth_voice_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sva_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sva_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic          cfg_data_i
);

  sva_pkg::ctrl_cmd_t cmd;  // sequencer -> datapath
  sva_pkg::dp_sts_t   sts;  // datapath -> sequencer

  assign cfg_ready_o = 1'b1;

  sva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  sva_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/sva_ctrl.sv */
// ----------------------------------------------------------------------------
// sva_ctrl
// Sequencer: accept, stack scan, stack update, voice scan, voice update, and a
// finish step for clear-all and idle codes.
module sva_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sva_pkg::dp_sts_t   sts_i,
  output sva_pkg::ctrl_cmd_t cmd_o,
  output logic               in_ready_o
);

  sva_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sva_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sva_pkg::S_IDLE: begin
        if (in_valid_i) begin
          // status cmd is the incoming item's here
          if (sts_i.cmd inside {sva_pkg::CMD_CLEAR, sva_pkg::CMD_NONE}) begin
            state_d = sva_pkg::S_FINISH;
          end else if (sts_i.mono) begin
            state_d = sva_pkg::S_SCAN_STK;
          end else begin
            state_d = sva_pkg::S_SCAN_VOC;
          end
        end
      end
      sva_pkg::S_SCAN_STK: begin
        if (sts_i.stk_done) state_d = sva_pkg::S_STK_UPD;
      end
      sva_pkg::S_STK_UPD: begin
        if (sts_i.to_voc) begin
          state_d = sva_pkg::S_SCAN_VOC;
        end else if (sts_i.out_free) begin
          state_d = sva_pkg::S_IDLE;
        end
      end
      sva_pkg::S_SCAN_VOC: begin
        if (sts_i.voc_done) state_d = sva_pkg::S_VOC_UPD;
      end
      sva_pkg::S_VOC_UPD, sva_pkg::S_FINISH: begin
        if (sts_i.out_free) state_d = sva_pkg::S_IDLE;
      end
      default: state_d = sva_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = sva_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      sva_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = sva_pkg::OP_ACCEPT;
      end
      sva_pkg::S_SCAN_STK: cmd_o.op = sva_pkg::OP_SCAN_STK;
      sva_pkg::S_STK_UPD: begin
        if (sts_i.to_voc || sts_i.out_free) cmd_o.op = sva_pkg::OP_STK_UPD;
      end
      sva_pkg::S_SCAN_VOC: cmd_o.op = sva_pkg::OP_SCAN_VOC;
      sva_pkg::S_VOC_UPD: begin
        if (sts_i.out_free) cmd_o.op = sva_pkg::OP_VOC_UPD;
      end
      sva_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op = (sts_i.cmd == sva_pkg::CMD_CLEAR) ? sva_pkg::OP_CLEAR
                                                       : sva_pkg::OP_NOEVT;
        end
      end
      default: cmd_o.op = sva_pkg::OP_NONE;
    endcase
  end

endmodule

/* sv/sva_dp.sv */
// ----------------------------------------------------------------------------
// sva_dp
// Voice table, note stack, event counter, scan registers and result register.
// ----------------------------------------------------------------------------
module sva_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sva_pkg::ctrl_cmd_t cmd_i,
  output sva_pkg::dp_sts_t   sts_o,
  input  sva_pkg::in_t       in_data_i,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic               cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sva_pkg::out_t      out_data_o
);

  localparam int V  = sva_pkg::VOICES;
  localparam int SD = sva_pkg::STACK_DEPTH;
  localparam int VW = sva_pkg::VIDX_W;
  localparam int SW = sva_pkg::SIDX_W;
  localparam int CW = sva_pkg::CNT_W;
  localparam int NW = sva_pkg::SCAN_W;
  localparam int TW = sva_pkg::STAMP_W;

  logic mono_q, mono_d, legato_q, legato_d, lfo_q, lfo_d;
  sva_pkg::in_t item_q, item_d;
  logic [TW-1:0] evt_q, evt_d;

  logic          act_q   [V];
  logic          act_d   [V];
  logic          gate_q  [V];
  logic          gate_d  [V];
  logic [6:0]    note_q  [V];
  logic [6:0]    note_d  [V];
  logic [6:0]    vel_q   [V];
  logic [6:0]    vel_d   [V];
  logic [TW-1:0] stamp_q [V];
  logic [TW-1:0] stamp_d [V];

  logic [6:0]    stk_q   [SD];
  logic [6:0]    stk_d   [SD];
  logic [CW-1:0] cnt_q, cnt_d;
  logic          any_q, any_d;

  logic [NW-1:0] idx_q, idx_d;
  logic          free_fnd_q, free_fnd_d, rel_fnd_q, rel_fnd_d, ag_q, ag_d;
  logic          sfnd_q, sfnd_d;
  logic [VW-1:0] free_idx_q, free_idx_d, best_q, best_d, rel_idx_q, rel_idx_d;
  logic [SW-1:0] sidx_q, sidx_d;
  logic [TW-1:0] min_q, min_d;

  logic          out_valid_q, out_valid_d;
  sva_pkg::out_t out_q, out_d;

  // combinational helpers
  logic          out_free;
  logic [VW-1:0] vi;
  logic [SW-1:0] si;
  logic          in_stk;
  logic [CW-1:0] new_cnt;
  logic [6:0]    top1, top2, prev;
  logic          hit0, to_voc;
  logic [VW-1:0] vsel;
  logic          shift_en;
  logic [SW-1:0] shift_from;

  assign out_free = !out_valid_q || out_ready_i;
  assign vi       = idx_q[VW-1:0];
  assign si       = idx_q[SW-1:0];
  assign in_stk   = 8'(idx_q) < 8'(cnt_q);
  assign new_cnt  = sfnd_q ? CW'(cnt_q - CW'(1)) : cnt_q;
  assign top1     = stk_q[SW'(cnt_q - CW'(1))];
  assign top2     = stk_q[SW'(cnt_q - CW'(2))];
  assign prev     = (new_cnt == '0) ? 7'd0 :
                    (sfnd_q && (8'(sidx_q) + 8'd1 == 8'(cnt_q))) ? top2 : top1;
  assign hit0     = (note_q[0] == item_q.note);
  assign to_voc   = (item_q.cmd == sva_pkg::CMD_NOTE_OFF) && hit0 && (prev == 7'd0);
  assign vsel     = free_fnd_q ? free_idx_q : best_q;

  assign sts_o.cmd      = (cmd_i.op == sva_pkg::OP_ACCEPT) ? in_data_i.cmd : item_q.cmd;
  assign sts_o.mono     = mono_q;
  assign sts_o.stk_done = (cnt_q == '0) || (8'(idx_q) + 8'd1 >= 8'(cnt_q));
  assign sts_o.voc_done = (idx_q == NW'(V - 1));
  assign sts_o.to_voc   = to_voc;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mono_d = mono_q; legato_d = legato_q; lfo_d = lfo_q;
    item_d = item_q; evt_d = evt_q;
    act_d = act_q; gate_d = gate_q; note_d = note_q; vel_d = vel_q; stamp_d = stamp_q;
    stk_d = stk_q; cnt_d = cnt_q; any_d = any_q;
    idx_d = idx_q; free_fnd_d = free_fnd_q; rel_fnd_d = rel_fnd_q; ag_d = ag_q;
    sfnd_d = sfnd_q; free_idx_d = free_idx_q; best_d = best_q; rel_idx_d = rel_idx_q;
    sidx_d = sidx_q; min_d = min_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    out_d = out_q;
    shift_en = 1'b0;
    shift_from = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        sva_pkg::REG_MONO:   mono_d   = cfg_data_i;
        sva_pkg::REG_LEGATO: legato_d = cfg_data_i;
        sva_pkg::REG_LFO:    lfo_d    = cfg_data_i;
        default: ;
      endcase
    end

    case (cmd_i.op)
      sva_pkg::OP_ACCEPT: begin
        item_d = in_data_i;
        if (in_data_i.cmd != sva_pkg::CMD_NONE && evt_q != {TW{1'b1}}) begin
          evt_d = evt_q + TW'(1);
        end
        idx_d = '0; free_fnd_d = 1'b0; rel_fnd_d = 1'b0; ag_d = 1'b0; sfnd_d = 1'b0;
      end
      sva_pkg::OP_SCAN_STK: begin
        if (in_stk && !sfnd_d && stk_q[si] == item_q.note) begin
          sfnd_d = 1'b1;
          sidx_d = si;
        end
        idx_d = NW'(idx_q + NW'(1));
      end
      sva_pkg::OP_SCAN_VOC: begin
        if (!act_q[vi] && !free_fnd_q) begin
          free_fnd_d = 1'b1;
          free_idx_d = vi;
        end
        if (idx_q == '0 || stamp_q[vi] < min_q) begin
          min_d  = stamp_q[vi];
          best_d = vi;
        end
        if (act_q[vi] && note_q[vi] == item_q.note && !rel_fnd_q) begin
          rel_fnd_d = 1'b1;
          rel_idx_d = vi;
        end else begin
          ag_d = ag_q | (act_q[vi] & gate_q[vi]);
        end
        idx_d = NW'(idx_q + NW'(1));
      end
      sva_pkg::OP_STK_UPD: begin
        idx_d = '0; free_fnd_d = 1'b0; rel_fnd_d = 1'b0; ag_d = 1'b0;
        if (item_q.cmd == sva_pkg::CMD_NOTE_ON) begin
          if (!sfnd_q) begin
            if (8'(cnt_q) < 8'(SD)) begin
              stk_d[SW'(cnt_q)] = item_q.note;
              cnt_d = CW'(cnt_q + CW'(1));
            end else begin
              shift_en = 1'b1;
              stk_d[SD-1] = item_q.note;
            end
          end
          act_d[0] = 1'b1; gate_d[0] = 1'b1;
          note_d[0] = item_q.note; vel_d[0] = item_q.velocity; stamp_d[0] = evt_q;
          any_d = 1'b1;
          out_valid_d = 1'b1;
          out_d = '0;
          out_d.voice_changed  = 1'b1;
          out_d.voice_note     = item_q.note;
          out_d.voice_velocity = item_q.velocity;
          out_d.voice_gate     = 1'b1;
          out_d.env_retrigger  = !legato_q;
          out_d.lfo_restart    = lfo_q && !any_q;
          out_d.global_gate    = 1'b1;
        end else begin
          if (sfnd_q) begin
            shift_en   = 1'b1;
            shift_from = sidx_q;
            cnt_d      = new_cnt;
          end
          if (!hit0) begin
            out_valid_d = 1'b1;
            out_d = '0;
            out_d.global_gate = any_q;
          end else if (prev != 7'd0) begin
            act_d[0] = 1'b1; gate_d[0] = 1'b1; note_d[0] = prev; stamp_d[0] = evt_q;
            any_d = 1'b1;
            out_valid_d = 1'b1;
            out_d = '0;
            out_d.voice_changed  = 1'b1;
            out_d.voice_note     = prev;
            out_d.voice_velocity = vel_q[0];
            out_d.voice_gate     = 1'b1;
            out_d.env_retrigger  = !legato_q;
            out_d.global_gate    = 1'b1;
          end
        end
      end
      sva_pkg::OP_VOC_UPD: begin
        out_valid_d = 1'b1;
        out_d = '0;
        if (item_q.cmd == sva_pkg::CMD_NOTE_ON) begin
          act_d[vsel] = 1'b1; gate_d[vsel] = 1'b1;
          note_d[vsel] = item_q.note; vel_d[vsel] = item_q.velocity;
          stamp_d[vsel] = evt_q;
          any_d = 1'b1;
          out_d.voice_changed  = 1'b1;
          out_d.voice_index    = 3'(vsel);
          out_d.voice_note     = item_q.note;
          out_d.voice_velocity = item_q.velocity;
          out_d.voice_gate     = 1'b1;
          out_d.env_retrigger  = !legato_q;
          out_d.stolen         = !free_fnd_q;
          out_d.lfo_restart    = lfo_q && !any_q;
          out_d.global_gate    = 1'b1;
        end else begin
          if (rel_fnd_q) begin
            act_d[rel_idx_q] = 1'b0; gate_d[rel_idx_q] = 1'b0;
            out_d.voice_changed  = 1'b1;
            out_d.voice_index    = 3'(rel_idx_q);
            out_d.voice_note     = note_q[rel_idx_q];
            out_d.voice_velocity = vel_q[rel_idx_q];
          end
          any_d = ag_q;
          out_d.global_gate = ag_q;
        end
      end
      sva_pkg::OP_CLEAR: begin
        for (int i = 0; i < V; i++) begin
          act_d[i] = 1'b0; gate_d[i] = 1'b0; note_d[i] = '0; vel_d[i] = '0;
          stamp_d[i] = '0;
        end
        cnt_d = '0;
        any_d = 1'b0;
        out_valid_d = 1'b1;
        out_d = '0;
      end
      sva_pkg::OP_NOEVT: begin
        out_valid_d = 1'b1;
        out_d = '0;
        out_d.global_gate = any_q;
      end
      default: ;
    endcase

    // drop one entry at shift_from, later entries move down
    if (shift_en) begin
      for (int i = 0; i < SD - 1; i++) begin
        if (SW'(i) >= shift_from) stk_d[i] = stk_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q   <= 1'b0;
      legato_q <= 1'b0;
      lfo_q    <= 1'b0;
      item_q   <= '0;
      evt_q    <= '0;
      for (int i = 0; i < V; i++) begin
        act_q[i]   <= 1'b0;
        gate_q[i]  <= 1'b0;
        note_q[i]  <= '0;
        vel_q[i]   <= '0;
        stamp_q[i] <= '0;
      end
      for (int i = 0; i < SD; i++) stk_q[i] <= '0;
      cnt_q       <= '0;
      any_q       <= 1'b0;
      idx_q       <= '0;
      free_fnd_q  <= 1'b0;
      rel_fnd_q   <= 1'b0;
      ag_q        <= 1'b0;
      sfnd_q      <= 1'b0;
      free_idx_q  <= '0;
      best_q      <= '0;
      rel_idx_q   <= '0;
      sidx_q      <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      mono_q      <= mono_d;
      legato_q    <= legato_d;
      lfo_q       <= lfo_d;
      item_q      <= item_d;
      evt_q       <= evt_d;
      act_q       <= act_d;
      gate_q      <= gate_d;
      note_q      <= note_d;
      vel_q       <= vel_d;
      stamp_q     <= stamp_d;
      stk_q       <= stk_d;
      cnt_q       <= cnt_d;
      any_q       <= any_d;
      idx_q       <= idx_d;
      free_fnd_q  <= free_fnd_d;
      rel_fnd_q   <= rel_fnd_d;
      ag_q        <= ag_d;
      sfnd_q      <= sfnd_d;
      free_idx_q  <= free_idx_d;
      best_q      <= best_d;
      rel_idx_q   <= rel_idx_d;
      sidx_q      <= sidx_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

/* sv/sva_checker.sv */
// ----------------------------------------------------------------------------
// sva_checker
// Port-level checks on the voice allocator result transactions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sva_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sva_pkg::out_t out_data_o
);

  `SVA_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")
  `SVA_IMPLY(a_quiet_zero, clk_i, rst_ni, out_valid_o && !out_data_o.voice_changed, out_data_o.voice_index == 3'd0 && out_data_o.voice_note == 7'd0 && !out_data_o.voice_gate && !out_data_o.stolen, "fields set without a voice change")
  `SVA_IMPLY(a_steal_gate, clk_i, rst_ni, out_valid_o && out_data_o.stolen, out_data_o.voice_changed && out_data_o.voice_gate && out_data_o.global_gate, "steal without a gated voice")
  `SVA_IMPLY(a_gate_global, clk_i, rst_ni, out_valid_o && out_data_o.voice_changed && out_data_o.voice_gate, out_data_o.global_gate, "gated voice but global gate low")

endmodule

bind synth_voice_allocator sva_checker u_sva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
